@@ hw/rtl/lpbs_pkg.sv @@
package lpbs_pkg;

	// width of one coordinate on the ports
	localparam int COORD_PORT_W = 32;

	// default geometry
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int COORD_WIDTH_DEF = 32;

	// probe counter width and saturation
	localparam int PROBE_W = 4;
	localparam logic [PROBE_W-1:0] PROBE_MAX = '1;

	// command codes
	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_SEARCH = 2'd2
	} func_t;

	// controller to datapath
	typedef struct packed {
		logic accept;    // latch the input word
		logic dispatch;  // execute clear / append, or set up a search
		logic probe;     // read the midpoint entry
		logic compare;   // compare query against the entry read
		logic load_out;  // move the result into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_search;
		logic range_ok;
		logic match;
	} sts_t;

endpackage

@@ hw/rtl/lpbs_ctrl.sv @@
module lpbs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  lpbs_pkg::sts_t sts,
	output lpbs_pkg::cmd_t cmd
);
	import lpbs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_PROBE,
		ST_COMPARE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:     cmd.accept   = in_valid;
			ST_DISPATCH: cmd.dispatch = 1'b1;
			ST_PROBE:    cmd.probe    = sts.range_ok;
			ST_COMPARE:  cmd.compare  = 1'b1;
			ST_FINISH:   cmd.load_out = slot_free;
			default:     cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// in finish the output register is either refilled or left waiting
			if (out_valid_q && out_ready && state_q != ST_FINISH)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_DISPATCH;
				end
				ST_DISPATCH: begin
					state_q <= sts.is_search ? ST_PROBE : ST_FINISH;
				end
				ST_PROBE: begin
					state_q <= sts.range_ok ? ST_COMPARE : ST_FINISH;
				end
				ST_COMPARE: begin
					state_q <= sts.match ? ST_FINISH : ST_PROBE;
				end
				ST_FINISH: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/lpbs_dp.sv @@
module lpbs_dp #(
	parameter int TABLE_DEPTH = lpbs_pkg::TABLE_DEPTH_DEF,
	parameter int COORD_WIDTH = lpbs_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lpbs_pkg::cmd_t                       cmd,
	output lpbs_pkg::sts_t                       sts,
	input  logic [1:0]                           func,
	input  logic signed [lpbs_pkg::COORD_PORT_W-1:0] coord_x,
	input  logic signed [lpbs_pkg::COORD_PORT_W-1:0] coord_y,
	input  logic signed [lpbs_pkg::COORD_PORT_W-1:0] coord_z,
	output logic                                 found,
	output logic [lpbs_pkg::PROBE_W-1:0]         probes,
	output logic                                 table_full
);
	import lpbs_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int LO_W  = CNT_W + 1;
	localparam int PT_W  = 3 * COORD_WIDTH;

	// query word
	logic [1:0]             func_q;
	logic [PT_W-1:0]        query_q;

	// table and fill count
	logic [PT_W-1:0]        mem [TABLE_DEPTH];
	logic [PT_W-1:0]        rd_q;
	logic [CNT_W-1:0]       count_q;
	logic                   is_full;

	// search window
	logic signed [LO_W-1:0] lo_q;
	logic signed [LO_W-1:0] hi_q;
	logic [LO_W:0]          mid_sum;
	logic [IDX_W-1:0]       mid;
	logic [IDX_W-1:0]       mid_q;
	logic [PROBE_W-1:0]     cnt_q;

	// result in progress and output register
	logic                   found_q;
	logic                   full_q;
	logic                   found_out_q;
	logic [PROBE_W-1:0]     probes_out_q;
	logic                   full_out_q;

	// compare
	logic signed [COORD_WIDTH-1:0] qx, qy, qz, ex, ey, ez;
	logic                   q_gt;

	assign is_full = (count_q == CNT_W'(TABLE_DEPTH));

	// window is non-empty only with both ends non-negative, so the sum is too
	assign mid_sum = {lo_q[LO_W-1], lo_q} + {hi_q[LO_W-1], hi_q};
	assign mid     = mid_sum[IDX_W:1];

	assign {qx, qy, qz} = query_q;
	assign {ex, ey, ez} = rd_q;

	always_comb begin
		if (qx != ex)
			q_gt = qx > ex;
		else if (qy != ey)
			q_gt = qy > ey;
		else
			q_gt = qz > ez;
	end

	assign sts.is_search = (func_q == FUNC_SEARCH);
	assign sts.range_ok  = (lo_q <= hi_q);
	assign sts.match     = (query_q == rd_q);

	assign found      = found_out_q;
	assign probes     = probes_out_q;
	assign table_full = full_out_q;

	// table write on append, registered read on probe
	always_ff @(posedge clk) begin
		if (cmd.dispatch && func_q == FUNC_APPEND && !is_full)
			mem[count_q[IDX_W-1:0]] <= query_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.probe)
			rd_q <= mem[mid];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q  <= func;
			query_q <= {coord_x[COORD_WIDTH-1:0], coord_y[COORD_WIDTH-1:0],
			            coord_z[COORD_WIDTH-1:0]};
		end
		if (cmd.probe)
			mid_q <= mid;
		if (cmd.dispatch) begin
			lo_q <= '0;
			hi_q <= $signed({1'b0, count_q}) - LO_W'(1);
		end else if (cmd.compare && !sts.match) begin
			if (q_gt)
				lo_q <= {{(LO_W - IDX_W){1'b0}}, mid_q} + LO_W'(1);
			else
				hi_q <= {{(LO_W - IDX_W){1'b0}}, mid_q} - LO_W'(1);
		end
		if (cmd.load_out) begin
			found_out_q  <= found_q;
			probes_out_q <= found_q ? cnt_q : '0;
			full_out_q   <= full_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
			full_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (cmd.dispatch) begin
				found_q <= 1'b0;
				cnt_q   <= '0;
				full_q  <= (func_q == FUNC_APPEND) && is_full;
				if (func_q == FUNC_CLEAR)
					count_q <= '0;
				else if (func_q == FUNC_APPEND && !is_full)
					count_q <= count_q + CNT_W'(1);
			end
			if (cmd.probe && cnt_q != PROBE_MAX)
				cnt_q <= cnt_q + PROBE_W'(1);
			if (cmd.compare && sts.match)
				found_q <= 1'b1;
		end
	end

endmodule

@@ hw/rtl/lexicographic_point_binary_search.sv @@
// Sorted table of 3D points with lexicographic binary search. Each input word
// carries a command (clear, append, search) and a Q16.16 point; each command
// gives exactly one result word with found, probes and table_full. Appends
// must arrive sorted by x, then y, then z; a full table drops the append and
// flags table_full. One command is in flight at a time. Clear, append and the
// unused code go from dispatch straight to the result; a search probes at
// most 11 entries of a 1024-entry table and none of an empty one: each probe
// is a registered read of the table memory followed by a compare of the
// query against the entry read, and a miss ends when the window is found
// empty. The result sits in an output register, so the next word is
// taken while the previous result still waits for out_ready.
module lexicographic_point_binary_search #(
	parameter int TABLE_DEPTH = lpbs_pkg::TABLE_DEPTH_DEF,
	parameter int COORD_WIDTH = lpbs_pkg::COORD_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// input words
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [1:0]                               func,
	input  logic signed [lpbs_pkg::COORD_PORT_W-1:0] coord_x,
	input  logic signed [lpbs_pkg::COORD_PORT_W-1:0] coord_y,
	input  logic signed [lpbs_pkg::COORD_PORT_W-1:0] coord_z,
	// result words
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic                                     found,
	output logic [lpbs_pkg::PROBE_W-1:0]             probes,
	output logic                                     table_full
);
	import lpbs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: accept, dispatch, probe/compare loop, result hand-off
	lpbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table memory, fill count, search window and result registers
	lpbs_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (func),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.found      (found),
		.probes     (probes),
		.table_full (table_full)
	);

`ifndef SYNTHESIS
	// a found point always reports at least one probe
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> probes != '0)
		else $error("found without probes");

	// a miss or a non-search reports no probes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> probes == '0)
		else $error("probes reported without a match");

	// a rejected append never reports a match
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && table_full))
		else $error("found and table_full together");

	// an accepted word closes the input until its result is produced
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");
`endif

endmodule
